>>> design/rlqr_pkg.sv
// Package: shared widths, register indexes, sequencer states and config struct.
`timescale 1ns / 1ps
`default_nettype none
package rlqr_pkg;

	localparam int VALUE_W    = 32;
	localparam int BUDGET_W   = 21;
	localparam int LCOUNT_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_COUNT,
		REG_OUTPUT_BUDGET,
		REG_LIMIT_ZERO,
		REG_LIMIT_ONE,
		REG_LIMIT_TWO,
		REG_LIMIT_THREE,
		REG_LIMIT_FOUR,
		REG_LIMIT_FIVE
	} rlqr_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_POST,
		ST_COUNT
	} rlqr_state_t;

	typedef struct packed {
		logic [LCOUNT_W-1:0] used;
		logic [BUDGET_W-1:0] budget;
	} rlqr_cfg_t;

endpackage
`default_nettype wire

>>> design/rlqr_cfg_regs.sv
// Configuration register file: limit count, output budget and the limit table.
`timescale 1ns / 1ps
`default_nettype none
module rlqr_cfg_regs
	import rlqr_pkg::*;
#(
	parameter int MAX_LIMITS = 6,
	localparam int IDX_W = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [IDX_W-1:0]      rd_idx,
	output rlqr_cfg_t                  cfg,
	output logic [VALUE_W-1:0]         rd_limit
);

	logic [LCOUNT_W-1:0] limit_count_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [VALUE_W-1:0]  limit_q [MAX_LIMITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_count_q <= '0;
			budget_q      <= '0;
			for (int j = 0; j < MAX_LIMITS; j++) begin
				limit_q[j] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIMIT_COUNT: begin
					limit_count_q <= cfg_data[LCOUNT_W-1:0];
				end
				REG_OUTPUT_BUDGET: begin
					budget_q <= cfg_data[BUDGET_W-1:0];
				end
				default: begin
					for (int j = 0; j < MAX_LIMITS; j++) begin
						if (cfg_index == CFG_IDX_W'(REG_LIMIT_ZERO) + CFG_IDX_W'(j)) begin
							limit_q[j] <= cfg_data[VALUE_W-1:0];
						end
					end
				end
			endcase
		end
	end

	// clamp the limit count to the table depth
	always_comb begin
		cfg.budget = budget_q;
		if (limit_count_q > LCOUNT_W'(MAX_LIMITS)) begin
			cfg.used = LCOUNT_W'(MAX_LIMITS);
		end else begin
			cfg.used = limit_count_q;
		end
	end

	assign rd_limit = limit_q[rd_idx];

endmodule
`default_nettype wire

>>> design/run_length_quantized_repeat_unit.sv
// Top level: run length quantizer with a one-compare-per-cycle limit scan.
//
// Usage: a frame of samples enters on in_valid/in_ready, one sample per
// request, with frame_last set on the frame's final sample. Each finished
// run becomes zero to MAX_LIMITS copies of its value on the output channel,
// cut short by the frame's output budget; after the final sample a count
// record (is_count high) carries the frame's total copy count. last_of_item
// marks the final result caused by one input request.
// Sequence: a sample that extends the current run or opens a frame,
// and is not the final sample, leaves the sequencer idle. A run end
// passes through accept, a limit scan with one compare per limit met
// plus one for the first limit missed or the table end (at most used+1,
// used = clamped limit count) through the single shared comparator, the
// copies and the load of the new run. A final sample then scans its own
// run, sends its copies, then a turnaround state and the count record.
// in_ready is high only while the sequencer is idle.
// A stalled receiver holds the sequencer in place; results wait unchanged.
// Reset clears the run state, frame flag and all configuration registers.
// Configuration must be written only while the block is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module run_length_quantized_repeat_unit
	import rlqr_pkg::*;
#(
	parameter int MAX_LIMITS = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VALUE_W-1:0]    sample,
	input  wire logic                  frame_last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [VALUE_W-1:0]         out_value,
	output logic                       is_count,
	output logic                       last_of_item
);

	localparam int IDX_W = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;
	localparam int CNT_W = $clog2(MAX_LIMITS + 1);

	rlqr_state_t state_q, state_d;

	logic [VALUE_W-1:0]  run_value_q;
	logic [VALUE_W-1:0]  run_length_q;
	logic [BUDGET_W-1:0] emitted_q;
	logic                in_frame_q;
	logic [VALUE_W-1:0]  sample_q;
	logic                last_q;
	logic                second_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    copies_q;
	logic [CNT_W-1:0]    left_q;

	rlqr_cfg_t          cfg;
	logic [VALUE_W-1:0] rd_limit;
	logic [CNT_W-1:0]   used;
	logic               hit;
	logic [BUDGET_W-1:0] space;
	logic [CNT_W-1:0]   final_copies;
	logic               in_acc;
	logic               out_acc;
	logic               differ;

	rlqr_cfg_regs #(
		.MAX_LIMITS(MAX_LIMITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rd_idx   (idx_q[IDX_W-1:0]),
		.cfg      (cfg),
		.rd_limit (rd_limit)
	);

	assign used    = cfg.used[CNT_W-1:0];
	assign hit     = (idx_q < used) && (rd_limit <= run_length_q);
	assign space   = (cfg.budget > emitted_q) ? cfg.budget - emitted_q : '0;
	assign final_copies = (space < BUDGET_W'(copies_q)) ? space[CNT_W-1:0] : copies_q;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign differ  = in_frame_q && (sample != run_value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		out_value    = run_value_q;
		is_count     = 1'b0;
		last_of_item = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (differ || frame_last) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!hit) begin
					state_d = (final_copies != '0) ? ST_EMIT : ST_POST;
				end
			end
			ST_EMIT: begin
				out_valid    = 1'b1;
				last_of_item = (left_q == CNT_W'(1)) && !second_q && !last_q;
				if (out_ready && left_q == CNT_W'(1)) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (second_q) begin
					state_d = ST_COUNT;
				end else if (last_q) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_COUNT: begin
				out_valid    = 1'b1;
				out_value    = VALUE_W'(emitted_q);
				is_count     = 1'b1;
				last_of_item = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= '0;
			run_length_q <= '0;
			emitted_q    <= '0;
			in_frame_q   <= 1'b0;
			last_q       <= 1'b0;
			second_q     <= 1'b0;
			idx_q        <= '0;
			copies_q     <= '0;
			left_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q   <= frame_last;
						idx_q    <= '0;
						copies_q <= '0;
						second_q <= !differ;
						if (!in_frame_q) begin
							run_value_q  <= sample;
							run_length_q <= VALUE_W'(1);
							emitted_q    <= '0;
							in_frame_q   <= 1'b1;
						end else if (!differ) begin
							if (run_length_q != '1) begin
								run_length_q <= run_length_q + VALUE_W'(1);
							end
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						idx_q    <= idx_q + CNT_W'(1);
						copies_q <= idx_q + CNT_W'(1);
					end else begin
						left_q <= final_copies;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						emitted_q <= emitted_q + BUDGET_W'(1);
						left_q    <= left_q - CNT_W'(1);
					end
				end
				ST_POST: begin
					if (!second_q) begin
						run_value_q  <= sample_q;
						run_length_q <= VALUE_W'(1);
						second_q     <= 1'b1;
						idx_q        <= '0;
						copies_q     <= '0;
					end
				end
				ST_COUNT: begin
					if (out_ready) begin
						in_frame_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// hold the new sample until the old run is flushed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
		end
	end

	a_emit_has_copies: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> left_q != '0)
		else $error("emit state with no copies left");

	a_copies_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		copies_q <= CNT_W'(MAX_LIMITS))
		else $error("copy count above table depth");

	a_copy_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !is_count |=> emitted_q == $past(emitted_q) + BUDGET_W'(1))
		else $error("copy delivered without count advance");

	a_count_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && is_count |=> !in_frame_q && state_q == ST_IDLE)
		else $error("count record did not close the frame");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for run_length_quantized_repeat_unit: frame stimulus, run-copy prediction, checks.
`timescale 1ns / 1ps
module tb_top;
	import rlqr_pkg::*;

	localparam int MAX_LIMITS   = 6;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYC   = 60;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 64;
	localparam int HOLD_CYC     = 400;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} sample_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_count;
		logic               last;
	} run_copy_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [VALUE_W-1:0]    sample = '0;
	logic                  frame_last = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [VALUE_W-1:0]    out_value;
	logic                  is_count;
	logic                  last_of_item;

	run_length_quantized_repeat_unit #(
		.MAX_LIMITS(MAX_LIMITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.frame_last  (frame_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.is_count    (is_count),
		.last_of_item(last_of_item)
	);

	sample_req_t sample_queue[$];
	run_copy_t   due_copies[$];
	int          pushed_count = 0;
	int          accepted_count = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	bit          quiet = 1'b0;
	run_copy_t   head_copy;

	logic [LCOUNT_W-1:0] lim_count_q = '0;
	logic [BUDGET_W-1:0] budget_q = '0;
	logic [VALUE_W-1:0]  lim_tbl [MAX_LIMITS];
	logic [VALUE_W-1:0]  next_lims [MAX_LIMITS];
	logic [VALUE_W-1:0]  run_val = '0;
	logic [VALUE_W-1:0]  run_len = '0;
	logic [BUDGET_W-1:0] emit_cnt = '0;
	bit                  frame_open = 1'b0;

	initial begin
		for (int i = 0; i < MAX_LIMITS; i++) begin
			lim_tbl[i] = '0;
			next_lims[i] = '0;
		end
	end

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic flush_run_copies();
		int unsigned         used;
		int unsigned         copies;
		bit                  stopped;
		logic [BUDGET_W-1:0] space;
		used = (lim_count_q > MAX_LIMITS) ? MAX_LIMITS : lim_count_q;
		copies = 0;
		stopped = 1'b0;
		for (int i = 0; i < used; i++) begin
			if (!stopped && lim_tbl[i] <= run_len)
				copies = i + 1;
			else
				stopped = 1'b1;
		end
		space = (budget_q > emit_cnt) ? budget_q - emit_cnt : '0;
		if (copies > space)
			copies = space;
		for (int i = 0; i < copies; i++)
			due_copies.push_back('{value: run_val, is_count: 1'b0, last: 1'b0});
		emit_cnt = emit_cnt + copies[BUDGET_W-1:0];
	endtask

	task automatic quantize_sample(logic [VALUE_W-1:0] value, logic last);
		int        n0;
		run_copy_t tail;
		n0 = due_copies.size();
		if (!frame_open) begin
			run_val = value;
			run_len = 1;
			emit_cnt = '0;
			frame_open = 1'b1;
		end else if (value == run_val) begin
			if (run_len != '1)
				run_len = run_len + 1;
		end else begin
			flush_run_copies();
			run_val = value;
			run_len = 1;
		end
		if (last) begin
			flush_run_copies();
			due_copies.push_back('{value: VALUE_W'(emit_cnt), is_count: 1'b1, last: 1'b0});
			frame_open = 1'b0;
		end
		if (due_copies.size() > n0) begin
			tail = due_copies.pop_back();
			tail.last = 1'b1;
			due_copies.push_back(tail);
		end
	endtask

	task automatic write_reg(rlqr_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_LIMIT_COUNT: begin
				lim_count_q = val[LCOUNT_W-1:0];
			end
			REG_OUTPUT_BUDGET: begin
				budget_q = val[BUDGET_W-1:0];
			end
			default: begin
				lim_tbl[idx - REG_LIMIT_ZERO] = val;
			end
		endcase
	endtask

	task automatic apply_config(logic [CFG_DATA_W-1:0] lc, logic [CFG_DATA_W-1:0] bud);
		write_reg(REG_LIMIT_COUNT, lc);
		write_reg(REG_OUTPUT_BUDGET, bud);
		for (int i = 0; i < MAX_LIMITS; i++)
			write_reg(rlqr_reg_t'(REG_LIMIT_ZERO + i), next_lims[i]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(logic [VALUE_W-1:0] value, logic last);
		sample_queue.push_back('{value: value, last: last});
		pushed_count++;
	endtask

	task automatic add_run(logic [VALUE_W-1:0] value, int len, bit close);
		for (int k = 0; k < len; k++)
			push_sample(value, close && (k == len - 1));
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return VALUE_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	task automatic add_frame(bit close);
		logic [VALUE_W-1:0] pool [3];
		int                 nruns;
		int                 rlen;
		for (int i = 0; i < 3; i++)
			pool[i] = pick_value();
		nruns = $urandom_range(1, 5);
		for (int r = 0; r < nruns; r++) begin
			rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
			add_run(pool[$urandom_range(0, 2)], rlen, close && (r == nruns - 1));
		end
	endtask

	task automatic add_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int k = 0; k < n; k++)
			push_sample($urandom, $urandom_range(0, 2) == 0);
	endtask

	task automatic randomize_config();
		logic [CFG_DATA_W-1:0] lc;
		logic [CFG_DATA_W-1:0] bud;
		int unsigned           base;
		lc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : MAX_LIMITS;
		case ($urandom_range(0, 5))
			0: bud = 0;
			1: bud = 1048576;
			2: bud = $urandom_range(0, 1048576);
			default: bud = $urandom_range(1, 40);
		endcase
		base = $urandom_range(0, 2);
		for (int i = 0; i < MAX_LIMITS; i++) begin
			case ($urandom_range(0, 9))
				0: next_lims[i] = $urandom;
				1: next_lims[i] = '1;
				2: next_lims[i] = '0;
				default: begin
					base = base + $urandom_range(0, 3);
					next_lims[i] = base;
				end
			endcase
		end
		apply_config(lc, bud);
	endtask

	task automatic wait_idle();
		while (accepted_count != pushed_count)
			@(posedge clk);
		while (due_copies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				quantize_sample(sample, frame_last);
				accepted_count++;
			end
			if (in_valid && !in_ready) begin
				// hold the request until accepted
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 11) - 1;
				in_valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				{sample, frame_last} <= sample_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!hold_done && accepted_count > 60 && sample_queue.size() > 30) begin
			hold_left <= HOLD_CYC;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_copies.size() == 0) begin
					if (fail_count < MAX_REPORTED)
						$display("unexpected result: value=%h is_count=%b last=%b",
							out_value, is_count, last_of_item);
					fail_count++;
				end else begin
					head_copy = due_copies.pop_front();
					if (head_copy.value !== out_value || head_copy.is_count !== is_count ||
						head_copy.last !== last_of_item) begin
						if (fail_count < MAX_REPORTED)
							$display("mismatch: expected value=%h is_count=%b last=%b, got value=%h is_count=%b last=%b",
								head_copy.value, head_copy.is_count, head_copy.last,
								out_value, is_count, last_of_item);
						fail_count++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset config: no copies, zero budget
		push_sample(32'h5, 1'b1);
		wait_idle();

		for (int i = 0; i < MAX_LIMITS; i++)
			next_lims[i] = i + 1;
		apply_config(MAX_LIMITS, 1048576);
		add_run(32'hFFFF_FFFF, 6, 1'b0);
		add_run(32'h0, 1, 1'b1);
		add_run(32'hA5A5_A5A5, 3, 1'b1);
		wait_idle();

		// broken prefix, oversized limit count; leave the frame open
		next_lims[0] = 32'h0;
		next_lims[1] = 32'h2;
		next_lims[2] = 32'hFFFF_FFFF;
		next_lims[3] = 32'h0;
		next_lims[4] = 32'h0;
		next_lims[5] = 32'h0;
		apply_config(7, 4);
		add_run(32'h1, 2, 1'b0);
		add_run(32'h2, 1, 1'b0);
		add_run(32'h3, 3, 1'b0);
		wait_idle();

		// drop the budget below the copies already sent
		apply_config(7, 1);
		add_run(32'h3, 1, 1'b0);
		add_run(32'h4, 1, 1'b1);
		wait_idle();

		for (int i = 0; i < MAX_LIMITS; i++)
			next_lims[i] = '0;
		apply_config(7, 1048576);
		add_run(32'h7, 1, 1'b0);
		add_run(32'h8, 1, 1'b1);
		wait_idle();

		apply_config(0, 1048576);
		add_run(32'h9, 1, 1'b1);
		wait_idle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			randomize_config();
			if (ph == RAND_PHASES - 1)
				quiet = 1'b1;
			start = pushed_count;
			while (pushed_count - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					add_noise();
				else
					add_frame(1'b1);
			end
			add_frame((ph == RAND_PHASES - 1) || ($urandom_range(0, 2) != 0));
			wait_idle();
		end

		fail_count += due_copies.size();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
design/rlqr_pkg.sv
design/rlqr_cfg_regs.sv
design/run_length_quantized_repeat_unit.sv
tb/sv/tb_top.sv
